// ===== design/sbaa_pkg.sv =====
// ----------------------------------------------------------------------------
// sbaa_pkg
// Shared types, codes and character mapping functions for the six-bit ASCII
// armor codec.
// ----------------------------------------------------------------------------
package sbaa_pkg;

   localparam int RSP_DEPTH = 5;   // most results one item can cause

   localparam logic [1:0] CODING_PASS  = 2'd0;
   localparam logic [1:0] CODING_PLAIN = 2'd1;
   localparam logic [1:0] CODING_SHIFT = 2'd2;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic CSR_CODING    = 1'b0;
   localparam logic CSR_DIRECTION = 1'b1;

   localparam logic [6:0] PAD_SYMBOL = 7'd64;
   localparam logic [7:0] PAD_BYTE   = 8'd64;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER = 8'd90;
   localparam logic [7:0] CHAR_LOW_SHIFTED = 8'd91;
   localparam logic [7:0] CHAR_TOP   = 8'd127;
   localparam logic [7:0] CHAR_STEP  = 8'd6;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   typedef struct packed {
      logic [7:0] out_value;
      logic       out_valid;
      logic       out_last;
      logic       length_error;
   } rsp_type;

   function automatic rsp_type mk_rsp(logic [7:0] v, logic vld, logic lst, logic err);
      rsp_type r;
      r.out_value    = v;
      r.out_valid    = vld;
      r.out_last     = lst;
      r.length_error = err;
      return r;
   endfunction

   // 6-bit symbol (or pad) to character
   function automatic logic [7:0] to_char(logic [6:0] sym, logic shifted);
      logic [7:0] c;
      c = CHAR_ZERO + {1'b0, sym};
      if (shifted && (c > CHAR_UPPER)) begin
         c = c + CHAR_STEP;
      end
      return c;
   endfunction

   // character to symbol value, mod 256
   function automatic logic [7:0] from_char(logic [7:0] ch, logic shifted);
      logic [7:0] c;
      c = ch;
      if (shifted && (c >= CHAR_LOW_SHIFTED) && (c <= CHAR_TOP)) begin
         c = c - CHAR_STEP;
      end
      return {1'b0, c[6:0]} - CHAR_ZERO;
   endfunction

endpackage

// ===== design/six_bit_ascii_armor_codec_core.sv =====
// ----------------------------------------------------------------------------
// six_bit_ascii_armor_codec_core
// Streaming radix-64 armor codec: three bytes to four printable characters
// and back, with pad handling, CR terminator and pass-through mode.
// ----------------------------------------------------------------------------
// Output: first result of an item is on rsp_ in the cycle after it is taken.
// Throughput: one item per cycle while each item causes at most one result
//   and rsp_ready is high; an item causing more results (up to 5) holds the
//   input until the result buffer has drained to its last entry.
// Items that cause no result are taken every cycle while no result is pending.
// Reset: synchronous; coding = pass through, direction = encode, no group held.
module six_bit_ascii_armor_codec_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_value,
   input  logic       req_carries_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_value,
   output logic       rsp_out_valid,
   output logic       rsp_out_last,
   output logic       rsp_length_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [1:0] csr_data
);
   import sbaa_pkg::*;

   logic [1:0] coding_ff, coding_in;
   logic       direction_ff, direction_in;
   logic [2:0] gp_ff, gp_in;
   logic [7:0] held_ff [4];
   logic [7:0] held_in [4];
   rsp_type    list_ff [RSP_DEPTH];
   rsp_type    list_in [RSP_DEPTH];
   logic [2:0] pend_ff, pend_in;

   rsp_type    new_list [RSP_DEPTH];
   logic [2:0] new_cnt;
   logic [2:0] new_gp;

   logic       accept, take, shifted;

   // encoder working values
   logic [1:0] enc_pos;
   logic [2:0] enc_after;
   logic       enc_full, enc_part;
   logic [7:0] d0, d1, d2;
   logic [6:0] s0, s1, s2, s3;

   // decoder working values
   logic [7:0] b0, b1, b2, b3;
   logic [7:0] y0, y1, y2;
   logic       send1, send2;

   assign csr_ready = 1'b1;
   assign rsp_valid = (pend_ff != 3'd0);
   assign take      = rsp_valid && rsp_ready;
   assign req_ready = (pend_ff == 3'd0) || ((pend_ff == 3'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;
   assign shifted   = (coding_ff == CODING_SHIFT);

   assign rsp_out_value    = list_ff[0].out_value;
   assign rsp_out_valid    = list_ff[0].out_valid;
   assign rsp_out_last     = list_ff[0].out_last;
   assign rsp_length_error = list_ff[0].length_error;

   // encoder group forming
   always_comb begin
      enc_pos   = (gp_ff > 3'd2) ? 2'd0 : gp_ff[1:0];
      enc_full  = req_carries_byte && (enc_pos == 2'd2);
      enc_after = req_carries_byte ? ({1'b0, enc_pos} + 3'd1) : {1'b0, enc_pos};
      if (enc_full) begin
         enc_after = 3'd0;
      end
      enc_part  = req_last && (enc_after != 3'd0);
      if (enc_full) begin
         d0 = held_ff[0];
         d1 = held_ff[1];
         d2 = req_value;
      end else begin
         d0 = (req_carries_byte && (enc_pos == 2'd0)) ? req_value : held_ff[0];
         d1 = (req_carries_byte && (enc_pos == 2'd1)) ? req_value : held_ff[1];
         d2 = 8'd0;
         if (enc_after < 3'd2) begin
            d1 = 8'd0;
         end
      end
      s0 = {1'b0, d0[5:0]};
      s1 = {1'b0, d0[7:6], d1[7:4]};
      s2 = (enc_full || (enc_after == 3'd2)) ? {1'b0, d2[7:6], d1[3:0]} : PAD_SYMBOL;
      s3 = enc_full ? {1'b0, d2[5:0]} : PAD_SYMBOL;
   end

   // decoder group unpacking
   always_comb begin
      b0 = from_char(held_ff[0], shifted);
      b1 = from_char(held_ff[1], shifted);
      b2 = from_char(held_ff[2], shifted);
      b3 = from_char(held_ff[3], shifted);
      y0 = {b1[5:4], 6'b0} | b0;
      y1 = {b1[3:0], b2[3:0]};
      y2 = {b2[5:4], 6'b0} | b3;
      // pads only count in the final group
      send1 = !req_last || (b2 != PAD_BYTE);
      send2 = !req_last || (b3 != PAD_BYTE);
   end

   // results of the offered item and next group state
   always_comb begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         new_list[i] = '0;
      end
      new_cnt = 3'd0;
      new_gp  = gp_ff;
      held_in = held_ff;
      if ((coding_ff != CODING_PLAIN) && (coding_ff != CODING_SHIFT)) begin
         if (req_carries_byte) begin
            new_list[0] = mk_rsp(req_value, 1'b1, req_last, 1'b0);
            new_cnt     = 3'd1;
         end else if (req_last) begin
            new_list[0] = mk_rsp(8'd0, 1'b0, 1'b1, 1'b0);
            new_cnt     = 3'd1;
         end
      end else if (direction_ff == DIR_ENCODE) begin
         if (req_carries_byte && !enc_full) begin
            held_in[enc_pos] = req_value;
         end
         new_gp = req_last ? 3'd0 : enc_after;
         if (enc_full || enc_part) begin
            new_list[0] = mk_rsp(to_char(s0, shifted), 1'b1, 1'b0, 1'b0);
            new_list[1] = mk_rsp(to_char(s1, shifted), 1'b1, 1'b0, 1'b0);
            new_list[2] = mk_rsp(to_char(s2, shifted), 1'b1, 1'b0, 1'b0);
            new_list[3] = mk_rsp(to_char(s3, shifted), 1'b1, 1'b0, 1'b0);
            new_cnt     = 3'd4;
         end
         if (req_last) begin
            if (enc_full || enc_part) begin
               new_list[4] = mk_rsp(CHAR_CR, 1'b1, 1'b1, 1'b0);
               new_cnt     = 3'd5;
            end else begin
               new_list[0] = mk_rsp(CHAR_CR, 1'b1, 1'b1, 1'b0);
               new_cnt     = 3'd1;
            end
         end
      end else begin
         if (req_last) begin
            new_gp = 3'd0;
            if (gp_ff == 3'd4) begin
               new_list[0] = mk_rsp(y0, 1'b1, !send1 && !send2, 1'b0);
               new_list[1] = send1 ? mk_rsp(y1, 1'b1, !send2, 1'b0)
                                   : mk_rsp(y2, 1'b1, 1'b1, 1'b0);
               new_list[2] = mk_rsp(y2, 1'b1, 1'b1, 1'b0);
               new_cnt     = 3'd1 + {2'b0, send1} + {2'b0, send2};
            end else begin
               new_list[0] = mk_rsp(8'd0, 1'b0, 1'b1, gp_ff != 3'd0);
               new_cnt     = 3'd1;
            end
         end else if (req_carries_byte) begin
            if (gp_ff == 3'd4) begin
               new_list[0] = mk_rsp(y0, 1'b1, 1'b0, 1'b0);
               new_list[1] = mk_rsp(y1, 1'b1, 1'b0, 1'b0);
               new_list[2] = mk_rsp(y2, 1'b1, 1'b0, 1'b0);
               new_cnt     = 3'd3;
               new_gp      = 3'd1;
            end else begin
               new_gp      = gp_ff + 3'd1;
            end
            // a full group restarts at slot 0, which is gp mod 4
            held_in[gp_ff[1:0]] = req_value;
         end
      end
   end

   // next state
   always_comb begin
      coding_in    = coding_ff;
      direction_in = direction_ff;
      gp_in        = gp_ff;
      list_in      = list_ff;
      pend_in      = pend_ff;
      if (accept) begin
         gp_in   = new_gp;
         list_in = new_list;
         pend_in = new_cnt;
      end else if (take) begin
         for (int i = 0; i < RSP_DEPTH - 1; i++) begin
            list_in[i] = list_ff[i + 1];
         end
         list_in[RSP_DEPTH - 1] = '0;
         pend_in = pend_ff - 3'd1;
      end
      if (csr_valid && csr_ready) begin
         gp_in = 3'd0;
         unique case (csr_index)
            CSR_CODING:    coding_in    = csr_data;
            CSR_DIRECTION: direction_in = csr_data[0];
            default:       coding_in    = coding_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coding_ff    <= CODING_PASS;
         direction_ff <= DIR_ENCODE;
         gp_ff        <= 3'd0;
         pend_ff      <= 3'd0;
      end else begin
         coding_ff    <= coding_in;
         direction_ff <= direction_in;
         gp_ff        <= gp_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_in;
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule
